@@ hdl/assert_macros.svh @@
// Concurrent assertion helpers; empty when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed (same cycle implication)");
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed (next cycle implication)");
`else
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

@@ hdl/dshc_pkg.sv @@
`default_nettype none

package dshc_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PREGAIN     = 3'd0,
    CFG_DRIVE_GAIN  = 3'd1,
    CFG_WET_MIX     = 3'd2,
    CFG_SOFT_BYPASS = 3'd3,
    CFG_HARD_BYPASS = 3'd4
  } cfg_reg_t;

  localparam logic [15:0] PREGAIN_RST    = 16'd4915;
  localparam logic [15:0] DRIVE_GAIN_RST = 16'd307;
  localparam logic [16:0] WET_MIX_RST    = 17'd0;
  localparam logic [16:0] MIX_FULL       = 17'h10000;

  // Entry k of the exp(-16k/depth) table, scaled so entry 0 equals 2^(bits-1).
  // step = floor(16 * 2^32 / depth). Elaboration only.
  function automatic logic [63:0] exp_rom_entry(input int k, input logic [63:0] step,
                                                input int bits);
    logic [63:0] ratio;
    logic [63:0] term;
    logic [63:0] e;
    ratio = 64'd1 << 32;
    term  = 64'd1 << 32;
    e     = 64'd1 << 32;
    // exp(-h) by Taylor series, Q32
    for (int n = 1; n <= 24; n++) begin
      term = (term * step + (64'd1 << 31)) >> 32;
      term = term / 64'(n);
      if ((n % 2) == 1) begin
        ratio = ratio - term;
      end else begin
        ratio = ratio + term;
      end
    end
    for (int i = 0; i < k; i++) begin
      e = (e * ratio + (64'd1 << 31)) >> 32;
    end
    return (e + (64'd1 << (32 - bits))) >> (33 - bits);
  endfunction

endpackage

`default_nettype wire

@@ hdl/dshc_exp_rom.sv @@
`default_nettype none

// exp table, two registered read ports at addr and addr+1
module dshc_exp_rom
  import dshc_pkg::*;
#(
  parameter int DEPTH = 256,
  parameter int BITS  = 24
) (
  input  logic                           clk,
  input  logic [$clog2(DEPTH+1)-1:0]     addr,
  output logic [BITS-1:0]                rd_a,
  output logic [BITS-1:0]                rd_b
);

  localparam int          AW       = $clog2(DEPTH + 1);
  localparam logic [63:0] EXP_STEP = (64'd16 << 32) / DEPTH;

  logic [BITS-1:0] rom [0:DEPTH];
  logic [AW-1:0]   addr_next;

  for (genvar k = 0; k <= DEPTH; k++) begin : g_rom
    assign rom[k] = BITS'(exp_rom_entry(k, EXP_STEP, BITS));
  end

  assign addr_next = addr + AW'(1);

  always_ff @(posedge clk) begin
    rd_a <= rom[addr];
    rd_b <= rom[addr_next];
  end

endmodule

`default_nettype wire

@@ hdl/distortion_soft_hard_clip.sv @@
// Soft/hard clip distortion with dry/wet blend, fully pipelined.
// Pipeline of 10 stages: done pulses when the output register of the last stage takes the result.
// Throughput: one request per clock; busy only reflects reset, the receiver cannot stall.
// Reset (rst, synchronous, active high): clears valid bits and loads register defaults;
// busy stays high for the cycle after rst falls, then the block takes one request a cycle.
`default_nettype none

`include "assert_macros.svh"

module distortion_soft_hard_clip
  import dshc_pkg::*;
#(
  parameter int EXP_TABLE_DEPTH = 256,
  parameter int SAMPLE_BITS     = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  // sample request / result
  input  logic                          start,
  output logic                          busy,
  input  logic signed [SAMPLE_BITS-1:0] sample_in,
  output logic                          done,
  output logic signed [SAMPLE_BITS-1:0] sample_out,
  // register writes
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data
);

  localparam int SB  = SAMPLE_BITS;
  localparam int IW  = SB + 5;    // pregained input, |x| < 16
  localparam int P1W = SB + 17;   // sample * pregain
  localparam int P2W = SB + 22;   // input * drive_gain
  localparam int WW  = SB + 12;   // driven wet value
  localparam int AW  = $clog2(EXP_TABLE_DEPTH + 1);
  localparam int PW  = SB + 3 + AW;  // table position, integer + fraction
  localparam int MW  = IW + 18;   // mix products and their sum
  localparam int NST = 9;         // valid bits ahead of the output register

  localparam logic [SB-1:0]        ONE_U     = {1'b1, {(SB-1){1'b0}}};
  localparam logic signed [WW-1:0] W_ONE     = {{(WW-SB){1'b0}}, ONE_U};
  localparam logic signed [WW-1:0] W_NEG_ONE = -W_ONE;
  localparam logic signed [IW-1:0] I_ONE     = {{(IW-SB){1'b0}}, ONE_U};
  localparam logic signed [IW-1:0] I_NEG_ONE = -I_ONE;
  localparam logic [AW-1:0]        IDX_LAST  = AW'(EXP_TABLE_DEPTH - 1);
  localparam logic signed [SB-1:0] OUT_MAX   = {1'b0, {(SB-1){1'b1}}};
  localparam logic signed [SB-1:0] OUT_MIN   = {1'b1, {(SB-1){1'b0}}};

  // ---------------------------------------------------------------------------
  // Control registers. The user must write them only between sample streams (the block does not
  // enforce this), so each stage reads them directly without a per-sample snapshot.
  // ---------------------------------------------------------------------------
  logic [15:0] pregain;
  logic [15:0] drive_gain;
  logic [16:0] wet_mix;
  logic        soft_bypass;
  logic        hard_bypass;

  logic accept;
  logic cfg_write;

  // busy is high only while in reset and the cycle after.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
    end else begin
      busy <= 1'b0;
    end
  end

  assign cfg_ready = !busy;
  assign cfg_write = cfg_valid && cfg_ready;
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      pregain     <= PREGAIN_RST;
      drive_gain  <= DRIVE_GAIN_RST;
      wet_mix     <= WET_MIX_RST;
      soft_bypass <= 1'b0;
      hard_bypass <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_PREGAIN:     pregain     <= cfg_data[15:0];
        CFG_DRIVE_GAIN:  drive_gain  <= cfg_data[15:0];
        CFG_WET_MIX:     wet_mix     <= cfg_data;
        CFG_SOFT_BYPASS: soft_bypass <= cfg_data[0];
        CFG_HARD_BYPASS: hard_bypass <= cfg_data[0];
        default: ;  // unmapped index: write dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Valid chain. vld[i] marks stage i+1; done is the output register's flag.
  // ---------------------------------------------------------------------------
  logic [NST-1:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      done <= 1'b0;
    end else begin
      vld  <= {vld[NST-2:0], accept};
      done <= vld[NST-1];
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath. Payload registers carry no reset; they advance every cycle.
  // ---------------------------------------------------------------------------
  // stage 1: sample * pregain
  logic signed [P1W-1:0] s1_prod;
  // stage 2: rounded pregained input (Q.23 at SB+5 bits)
  logic signed [P1W-1:0] rnd1;
  logic signed [IW-1:0]  s2_input;
  // stage 3: input * drive_gain
  logic signed [P2W-1:0] s3_prod;
  logic signed [IW-1:0]  s3_input;
  // stage 4: wet value after optional drive
  logic signed [P2W-1:0] rnd2;
  logic                  drive_en;
  logic signed [WW-1:0]  s4_w;
  logic signed [IW-1:0]  s4_input;
  // stage 5: magnitude, table index and fraction; linear path for soft bypass
  logic                  neg;
  logic [WW-1:0]         mag;
  logic [PW-1:0]         pos;
  logic [AW-1:0]         idx_raw;
  logic signed [IW-1:0]  lin;
  logic                  s5_neg;
  logic                  s5_big;
  logic [AW-1:0]         s5_idx;
  logic [15:0]           s5_fr;
  logic signed [IW-1:0]  s5_lin;
  logic signed [IW-1:0]  s5_input;
  // stage 6: table read (registered inside the ROM)
  logic [SB-1:0]         rom_a;
  logic [SB-1:0]         rom_b;
  logic                  s6_neg;
  logic                  s6_big;
  logic [15:0]           s6_fr;
  logic signed [IW-1:0]  s6_lin;
  logic signed [IW-1:0]  s6_input;
  // stage 7: slope * fraction
  logic [SB+15:0]        s7_prod;
  logic [SB-1:0]         s7_a;
  logic                  s7_neg;
  logic                  s7_big;
  logic signed [IW-1:0]  s7_lin;
  logic signed [IW-1:0]  s7_input;
  // stage 8: final wet value
  logic [SB+15:0]        rnd3;
  logic [SB-1:0]         exp_val;
  logic [SB-1:0]         soft_mag;
  logic signed [IW-1:0]  soft_ext;
  logic signed [IW-1:0]  s8_wet;
  logic signed [IW-1:0]  s8_input;
  // stage 9: blend products
  logic [16:0]           mix_c;
  logic [16:0]           dry_c;
  logic signed [MW-1:0]  s9_pw;
  logic signed [MW-1:0]  s9_pd;
  // stage 10: sum, round, saturate
  logic signed [MW-1:0]  acc;
  logic signed [MW-17:0] yv;
  logic signed [SB-1:0]  y_sat;

  always_comb begin
    rnd1     = s1_prod + P1W'(2048);
    rnd2     = s3_prod + P2W'(128);
    drive_en = !soft_bypass || !hard_bypass;

    neg     = s4_w[WW-1];
    mag     = neg ? WW'(-s4_w) : WW'(s4_w);
    pos     = PW'(mag[SB+2:0]) * PW'(EXP_TABLE_DEPTH);
    idx_raw = pos[PW-1:SB+3];
    // soft bypass: either hard limit or straight through (then wet == input)
    if (hard_bypass) begin
      lin = s4_w[IW-1:0];
    end else if (s4_w > W_ONE) begin
      lin = I_ONE;
    end else if (s4_w < W_NEG_ONE) begin
      lin = I_NEG_ONE;
    end else begin
      lin = s4_w[IW-1:0];
    end

    // interpolate exp, then 1 - exp; hard limit never bites on this path
    rnd3     = s7_prod + (SB+16)'(32768);
    exp_val  = s7_a - rnd3[SB+15:16];
    soft_mag = s7_big ? ONE_U : ONE_U - exp_val;
    soft_ext = {{(IW-SB){1'b0}}, soft_mag};

    mix_c = wet_mix[16] ? MIX_FULL : wet_mix;
    dry_c = MIX_FULL - mix_c;

    acc = s9_pw + s9_pd + MW'(32768);
    yv  = acc[MW-1:16];
    if (yv > $signed((MW-16)'(OUT_MAX))) begin
      y_sat = OUT_MAX;
    end else if (yv < $signed({{(MW-16-SB){1'b1}}, OUT_MIN})) begin
      y_sat = OUT_MIN;
    end else begin
      y_sat = yv[SB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    s1_prod  <= P1W'(sample_in) * P1W'($signed({1'b0, pregain}));

    s2_input <= rnd1[P1W-1:12];

    s3_prod  <= P2W'(s2_input) * P2W'($signed({1'b0, drive_gain}));
    s3_input <= s2_input;

    s4_w     <= drive_en ? rnd2[WW+7:8] : {{(WW-IW){s3_input[IW-1]}}, s3_input};
    s4_input <= s3_input;

    s5_neg   <= neg;
    s5_big   <= |mag[WW-1:SB+3];
    s5_idx   <= (idx_raw > IDX_LAST) ? IDX_LAST : idx_raw;
    s5_fr    <= pos[SB+2 -: 16];
    s5_lin   <= lin;
    s5_input <= s4_input;

    s6_neg   <= s5_neg;
    s6_big   <= s5_big;
    s6_fr    <= s5_fr;
    s6_lin   <= s5_lin;
    s6_input <= s5_input;

    s7_prod  <= (SB+16)'(rom_a - rom_b) * (SB+16)'(s6_fr);
    s7_a     <= rom_a;
    s7_neg   <= s6_neg;
    s7_big   <= s6_big;
    s7_lin   <= s6_lin;
    s7_input <= s6_input;

    s8_wet   <= soft_bypass ? s7_lin : (s7_neg ? -soft_ext : soft_ext);
    s8_input <= s7_input;

    s9_pw    <= MW'(s8_wet) * MW'($signed({1'b0, mix_c}));
    s9_pd    <= MW'(s8_input) * MW'($signed({1'b0, dry_c}));

    sample_out <= y_sat;
  end

  // Table lookup: T[idx] and T[idx+1] are registered in the ROM, ready in the cycle after the index is known.
  dshc_exp_rom #(
    .DEPTH (EXP_TABLE_DEPTH),
    .BITS  (SB)
  ) u_exp_rom (
    .clk  (clk),
    .addr (s5_idx),
    .rd_a (rom_a),
    .rd_b (rom_b)
  );

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // fixed pipeline depth: a result seen with done always goes back to an accepted request (start && !busy)
  `ASSERT_IMPLY(a_latency, clk, rst, done, $past(start && !busy, 10))
  // with any clipper on, the wet value never leaves [-1, +1]
  `ASSERT_IMPLY(a_wet_range, clk, rst, vld[7] && drive_en, (s8_wet <= I_ONE) && (s8_wet >= I_NEG_ONE))
  // exp table decreases, so the interpolation slope is never negative
  `ASSERT_NEXT(a_rom_slope, clk, rst, vld[4], rom_a >= rom_b)

endmodule

`default_nettype wire

@@ tb/tb.sv @@
`default_nettype none

module tb
  import dshc_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int  SBITS     = 24;
  localparam int  TAB_DEPTH = 256;
  localparam longint ONE    = longint'(1) << (SBITS - 1);
  // pipeline is 10 stages deep; give it a little margin when draining
  localparam int  PIPE_SLACK  = 14;
  localparam int  DRAIN_LIMIT = 4000;
  localparam int  N_RAND_PHASES = 12;
  localparam int  PRINT_CAP = 50;

  // indexes the block must ignore
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_FIRST = 3'd5;
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_LAST  = 3'd7;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     start = 1'b0;
  logic                     busy;
  logic signed [SBITS-1:0]  sample_in = '0;
  logic                     done;
  logic signed [SBITS-1:0]  sample_out;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_W-1:0]     cfg_index = '0;
  logic [CFG_DATA_W-1:0]    cfg_data = '0;

  distortion_soft_hard_clip u_top (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .sample_in  (sample_in),
    .done       (done),
    .sample_out (sample_out),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: register shadow and the exp(-16k/depth) table
  // ---------------------------------------------------------------------------
  logic [15:0] cur_pregain = PREGAIN_RST;
  logic [15:0] cur_drive   = DRIVE_GAIN_RST;
  logic [16:0] cur_mix     = WET_MIX_RST;
  logic        cur_soft_byp = 1'b0;
  logic        cur_hard_byp = 1'b0;
  longint      exp_tab [0:TAB_DEPTH];

  logic signed [SBITS-1:0] pending_samples [$];   // requests not yet accepted
  logic signed [SBITS-1:0] expected_out [$];      // predicted outputs, oldest first

  int  err_count = 0;
  int  samples_sent = 0;
  int  results_seen = 0;
  int  reg_writes = 0;
  int  settings_run = 0;

  // sender pacing
  int  burst_left = 0;
  int  gap_left = 0;
  bit  gapless = 1'b0;
  bit  pause_req = 1'b0;

  task automatic report_mismatch(input string what, input logic signed [SBITS-1:0] got,
                                 input logic signed [SBITS-1:0] want);
    if (err_count < PRINT_CAP)
      $display("MISMATCH at %0t: %s (got %0d, expected %0d)", $realtime, what, got, want);
    err_count++;
  endtask

  // floor((v + half LSB) / 2^sh); >>> on a signed longint floors
  function automatic longint rnd_shift(input longint v, input int sh);
    return (v + (longint'(1) << (sh - 1))) >>> sh;
  endfunction

  function automatic logic signed [SBITS-1:0] dist_predict(input logic signed [SBITS-1:0] s);
    longint x, dry, wet, u, mag, pos, idx, frac, ta, tb_, m, y;
    bit     neg;
    x   = s;
    dry = rnd_shift(x * longint'(cur_pregain), 12);
    wet = dry;
    // drive gain only applies when at least one clipper is in the path
    if (!cur_soft_byp || !cur_hard_byp)
      wet = rnd_shift(wet * longint'(cur_drive), 8);
    if (!cur_soft_byp) begin
      neg = wet < 0;
      u   = neg ? -wet : wet;
      if (u >= (longint'(16) << (SBITS - 1))) begin
        mag = ONE;
      end else begin
        // table position in Q(SBITS+3); interpolate on the top 16 fraction bits
        pos  = u * TAB_DEPTH;
        idx  = pos >> (SBITS + 3);
        frac = (pos & ((longint'(1) << (SBITS + 3)) - 1)) >> (SBITS + 3 - 16);
        if (idx > TAB_DEPTH - 1)
          idx = TAB_DEPTH - 1;
        ta  = exp_tab[idx];
        tb_ = exp_tab[idx + 1];
        mag = ONE - (ta - rnd_shift((ta - tb_) * frac, 16));
      end
      wet = neg ? -mag : mag;
    end
    if (!cur_hard_byp) begin
      if (wet > ONE)
        wet = ONE;
      if (wet < -ONE)
        wet = -ONE;
    end
    // mix saturates at fully wet
    m = (cur_mix > MIX_FULL) ? longint'(MIX_FULL) : longint'(cur_mix);
    y = rnd_shift(wet * m + dry * (longint'(MIX_FULL) - m), 16);
    if (y > ONE - 1)
      y = ONE - 1;
    if (y < -ONE)
      y = -ONE;
    return y[SBITS-1:0];
  endfunction

  // shadow update, bits above each register's width are dropped
  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_PREGAIN:     cur_pregain  = data[15:0];
      CFG_DRIVE_GAIN:  cur_drive    = data[15:0];
      CFG_WET_MIX:     cur_mix      = data[16:0];
      CFG_SOFT_BYPASS: cur_soft_byp = data[0];
      CFG_HARD_BYPASS: cur_hard_byp = data[0];
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: one request per accepted start, paced in bursts
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_out.push_back(dist_predict(sample_in));
        void'(pending_samples.pop_front());
        samples_sent++;
      end
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (!pause_req && pending_samples.size() > 0) begin
        start     <= 1'b1;
        sample_in <= pending_samples[0];
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 48);
          if (gapless || $urandom_range(0, 3) == 0)
            gap_left = 0;
          else
            gap_left = $urandom_range(1, 7);
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: each done strobe is checked against the oldest prediction
  // ---------------------------------------------------------------------------
  logic signed [SBITS-1:0] want_out;

  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_out.size() == 0) begin
        report_mismatch("result with no request waiting", sample_out, '0);
      end else begin
        want_out = expected_out.pop_front();
        results_seen++;
        if (sample_out !== want_out)
          report_mismatch("sample_out", sample_out, want_out);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  // register write on the cfg channel; caller makes sure the pipe is empty
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, data);
    reg_writes++;
    cfg_valid <= 1'b0;
  endtask

  // wait for the sender to run dry and all results to come back, then let the
  // pipe settle; a stuck pipe is reported rather than waited on forever
  task automatic drain_pipe();
    int waited;
    waited = 0;
    do begin
      @(negedge clk);
      waited++;
    end while ((pending_samples.size() != 0 || start || expected_out.size() != 0) &&
               waited < DRAIN_LIMIT);
    if (expected_out.size() != 0) begin
      report_mismatch("results never arrived", '0, expected_out[0]);
      expected_out.delete();
    end
    repeat (PIPE_SLACK) @(negedge clk);
  endtask

  function automatic logic [CFG_DATA_W-1:0] rand_gain(input logic [15:0] lo, input logic [15:0] hi);
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return {1'($urandom_range(0, 1)), 16'hFFFF};
      2, 3:    return 17'($urandom_range(lo, hi));
      default: return 17'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand_mix();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return MIX_FULL;
      2:       return '1;
      3, 4:    return 17'($urandom_range(0, 65536));
      default: return 17'($urandom);
    endcase
  endfunction

  function automatic logic signed [SBITS-1:0] rand_sample();
    logic signed [SBITS-1:0] r;
    r = SBITS'($urandom);
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return r;
      5, 6, 7:       return r >>> $urandom_range(4, 20);   // quiet signal, soft clip knee
      8:             return $urandom_range(0, 1) ? {1'b1, {(SBITS-1){1'b0}}}
                                                 : {1'b0, {(SBITS-1){1'b1}}};
      default:       return SBITS'($urandom_range(0, 16)) - SBITS'(8);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  logic signed [SBITS-1:0] corner_vals [5];

  initial begin
    logic [63:0] step, ratio, term, e;
    int n_items;

    // exp table: Q32 step ratio from a 24 term series, then repeated multiply
    step  = (64'd16 << 32) / 64'(TAB_DEPTH);
    ratio = 64'd1 << 32;
    term  = 64'd1 << 32;
    e     = 64'd1 << 32;
    for (int n = 1; n <= 24; n++) begin
      term = (term * step + (64'd1 << 31)) >> 32;
      term = term / 64'(n);
      ratio = (n % 2 == 1) ? ratio - term : ratio + term;
    end
    for (int k = 0; k <= TAB_DEPTH; k++) begin
      exp_tab[k] = longint'((e + (64'd1 << (32 - SBITS))) >> (33 - SBITS));
      e = (e * ratio + (64'd1 << 31)) >> 32;
    end

    corner_vals[0] = {1'b1, {(SBITS-1){1'b0}}};   // most negative
    corner_vals[1] = {1'b0, {(SBITS-1){1'b1}}};   // most positive
    corner_vals[2] = '0;
    corner_vals[3] = SBITS'(1);
    corner_vals[4] = SBITS'(-1);

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // --- directed: register defaults, mix 0 so output is the scaled dry path
    @(negedge clk);
    foreach (corner_vals[i]) pending_samples.push_back(corner_vals[i]);
    drain_pipe();
    settings_run++;

    // --- directed: max gains with bits above width set, full wet, both clippers,
    // plus a write to an unused index that must change nothing
    write_reg(CFG_PREGAIN, '1);
    write_reg(CFG_DRIVE_GAIN, '1);
    write_reg(CFG_WET_MIX, MIX_FULL);
    write_reg(CFG_SOFT_BYPASS, 17'h1FFFE);
    write_reg(CFG_HARD_BYPASS, '0);
    write_reg(IDX_SPARE_FIRST, '1);
    @(negedge clk);
    foreach (corner_vals[i]) pending_samples.push_back(corner_vals[i]);
    drain_pipe();
    settings_run++;

    // --- directed: mix above full saturates, drive gain at zero, hard clip only
    write_reg(CFG_PREGAIN, 17'd4096);
    write_reg(CFG_DRIVE_GAIN, '0);
    write_reg(CFG_WET_MIX, '1);
    write_reg(CFG_SOFT_BYPASS, 17'd1);
    write_reg(CFG_HARD_BYPASS, '0);
    @(negedge clk);
    foreach (corner_vals[i]) pending_samples.push_back(corner_vals[i]);
    drain_pipe();
    settings_run++;

    // --- directed: unity gains, hard clip holds +1.0 which must saturate at output
    write_reg(CFG_DRIVE_GAIN, 17'd256);
    write_reg(CFG_WET_MIX, MIX_FULL);
    write_reg(IDX_SPARE_LAST, 17'h0AAAA);
    @(negedge clk);
    foreach (corner_vals[i]) pending_samples.push_back(corner_vals[i]);
    drain_pipe();
    settings_run++;

    // --- directed: both clippers out (no drive gain), big pregain overflows the blend
    write_reg(CFG_PREGAIN, 17'hFFFF);
    write_reg(CFG_DRIVE_GAIN, 17'd25000);
    write_reg(CFG_WET_MIX, 17'd32768);
    write_reg(CFG_SOFT_BYPASS, 17'h1FFFF);
    write_reg(CFG_HARD_BYPASS, 17'h00001);
    @(negedge clk);
    foreach (corner_vals[i]) pending_samples.push_back(corner_vals[i]);
    drain_pipe();
    settings_run++;

    // --- random phases: fresh settings each time, random samples
    for (int ph = 0; ph < N_RAND_PHASES; ph++) begin
      write_reg(CFG_PREGAIN, rand_gain(16'd4915, 16'd45875));
      write_reg(CFG_DRIVE_GAIN, rand_gain(16'd307, 16'd25907));
      write_reg(CFG_WET_MIX, rand_mix());
      write_reg(CFG_SOFT_BYPASS, 17'($urandom));
      write_reg(CFG_HARD_BYPASS, 17'($urandom));
      if ($urandom_range(0, 3) == 0)
        write_reg(IDX_SPARE_FIRST + 3'($urandom_range(0, IDX_SPARE_LAST - IDX_SPARE_FIRST)),
                  17'($urandom));
      // three phases run back to back with no idle cycles
      gapless = (ph % 5 == 1);
      n_items = $urandom_range(80, 110);
      @(negedge clk);
      for (int i = 0; i < n_items; i++) pending_samples.push_back(rand_sample());
      if (ph == 3) begin
        // hold the sender mid-stream until the pipe has fully emptied
        repeat ($urandom_range(5, 30)) @(negedge clk);
        pause_req = 1'b1;
        repeat (2) @(negedge clk);
        while (expected_out.size() != 0) @(negedge clk);
        repeat ($urandom_range(1, 10)) @(negedge clk);
        pause_req = 1'b0;
      end
      drain_pipe();
      settings_run++;
    end

    $display("covered %0d samples across %0d register settings (%0d register writes)",
             samples_sent, settings_run, reg_writes);
    $display("checked %0d results, %0d mismatches", results_seen, err_count);
    if (err_count == 0) begin
      $display("distortion_soft_hard_clip verification clean");
    end else begin
      $display("distortion_soft_hard_clip verification failed");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #5ms;
    $display("watchdog expired");
    $display("distortion_soft_hard_clip verification failed");
    $finish;
  end

endmodule

`default_nettype wire
